[sv/mlr_pkg.sv]
// Package for the midpoint line rasterizer.
// Shared types and default constants; no dependencies.
`default_nettype none

package mlr_pkg;

    localparam int COORD_WIDTH_DEF = 6;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } mlr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } mlr_cmd_t;

    typedef struct packed {
        logic fin;
    } mlr_sts_t;

endpackage

`default_nettype wire

[sv/mlr_ctrl.sv]
// Controller state machine of the midpoint line rasterizer.
// Drives the handshakes and issues load/step commands; uses mlr_pkg.
`default_nettype none

module mlr_ctrl
    import mlr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire mlr_sts_t sts,
    output mlr_cmd_t      cmd
);

    mlr_state_t state_reg;
    mlr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/mlr_dp.sv]
// Datapath of the midpoint line rasterizer: octant setup and decision stepper.
// Controlled by mlr_ctrl through mlr_cmd_t / mlr_sts_t; uses mlr_pkg.
`default_nettype none

module mlr_dp
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire mlr_cmd_t                      cmd,
    output mlr_sts_t                           sts,
    output logic signed [COORD_WIDTH-1:0]      pixel_x,
    output logic signed [COORD_WIDTH-1:0]      pixel_y,
    output logic                               last
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 3;

    logic signed [W:0]    dx, dy, ndx, ndy, dmaj_w, dmi, ndmi;
    logic [W-1:0]         adx, ady, dmaj, dmin;
    logic                 steep, swap, neg;
    logic signed [W-1:0]  ma0_raw, ma1_raw, mi0_raw, mi1_raw, ma0, ma1, mi0, mi1;
    logic signed [DW-1:0] dec0;

    logic signed [W-1:0]  major_pos_reg, major_pos_next;
    logic signed [W-1:0]  minor_pos_reg, minor_pos_next;
    logic signed [W-1:0]  major_end_reg, major_end_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [1:0]           octant_code_reg, octant_code_next;
    logic [W:0]           dmaj2_reg, dmaj2_next;
    logic [W:0]           dmin2_reg, dmin2_next;
    logic                 dec_pos;

    // setup
    always_comb
    begin
        dx  = {end_x[W-1], end_x} - {start_x[W-1], start_x};
        dy  = {end_y[W-1], end_y} - {start_y[W-1], start_y};
        ndx = -dx;
        ndy = -dy;
        adx = dx[W] ? ndx[W-1:0] : dx[W-1:0];
        ady = dy[W] ? ndy[W-1:0] : dy[W-1:0];
        steep = ady > adx;
        ma0_raw = steep ? start_y : start_x;
        mi0_raw = steep ? start_x : start_y;
        ma1_raw = steep ? end_y : end_x;
        mi1_raw = steep ? end_x : end_y;
        swap = ma1_raw < ma0_raw;
        ma0  = swap ? ma1_raw : ma0_raw;
        ma1  = swap ? ma0_raw : ma1_raw;
        mi0  = swap ? mi1_raw : mi0_raw;
        mi1  = swap ? mi0_raw : mi1_raw;
        dmaj_w = {ma1[W-1], ma1} - {ma0[W-1], ma0};
        dmaj   = dmaj_w[W-1:0];
        dmi    = {mi1[W-1], mi1} - {mi0[W-1], mi0};
        ndmi   = -dmi;
        neg    = dmi[W];
        dmin   = neg ? ndmi[W-1:0] : dmi[W-1:0];
        dec0   = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    end

    assign dec_pos = !decision_reg[DW-1] && (|decision_reg);
    assign sts.fin = major_pos_reg >= major_end_reg;

    always_comb
    begin
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_end_next   = major_end_reg;
        decision_next    = decision_reg;
        octant_code_next = octant_code_reg;
        dmaj2_next       = dmaj2_reg;
        dmin2_next       = dmin2_reg;
        if (cmd.load)
        begin
            major_pos_next   = ma0;
            minor_pos_next   = mi0;
            major_end_next   = ma1;
            decision_next    = dec0;
            octant_code_next = {neg, steep};
            dmaj2_next       = {dmaj, 1'b0};
            dmin2_next       = {dmin, 1'b0};
        end
        else if (cmd.step)
        begin
            major_pos_next = major_pos_reg + W'(1);
            if (dec_pos)
            begin
                minor_pos_next = octant_code_reg[1] ? minor_pos_reg - W'(1)
                                                    : minor_pos_reg + W'(1);
                decision_next  = decision_reg + $signed({2'b00, dmin2_reg})
                               - $signed({2'b00, dmaj2_reg});
            end
            else
            begin
                decision_next = decision_reg + $signed({2'b00, dmin2_reg});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_end_reg   <= '0;
            decision_reg    <= '0;
            octant_code_reg <= '0;
            dmaj2_reg       <= '0;
            dmin2_reg       <= '0;
        end
        else
        begin
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_end_reg   <= major_end_next;
            decision_reg    <= decision_next;
            octant_code_reg <= octant_code_next;
            dmaj2_reg       <= dmaj2_next;
            dmin2_reg       <= dmin2_next;
        end
    end

    assign pixel_x = octant_code_reg[0] ? minor_pos_reg : major_pos_reg;
    assign pixel_y = octant_code_reg[0] ? major_pos_reg : minor_pos_reg;
    assign last    = sts.fin;

endmodule

`default_nettype wire

[sv/midpoint_line_rasterizer.sv]
// Top level of the midpoint line rasterizer.
// Instantiates mlr_ctrl and mlr_dp; uses mlr_pkg.
//
// One input item is a line with two signed endpoints; the block emits every
// pixel of it, both endpoints included, along increasing major axis (y when
// |dy| > |dx|, else x), and flags the final pixel with last. The item is
// loaded into the stepper registers, from which one pixel is offered per
// cycle while out_ready is high; a line has N pixels (1 to 2^COORD_WIDTH).
// A new line is accepted only once the last pixel of the previous one has
// been taken.
`default_nettype none

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      pixel_x,
    output logic signed [COORD_WIDTH-1:0]      pixel_y,
    output logic                               last
);

    mlr_cmd_t cmd;
    mlr_sts_t sts;

    mlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mlr_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cmd     (cmd),
        .sts     (sts),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .last    (last)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a line is in progress");

    a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no pixel after line accepted");

    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("line ended before last pixel");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not free after last pixel");

endmodule

`default_nettype wire

[dv/midpoint_line_rasterizer_tb.sv]
// Self-checking testbench for midpoint_line_rasterizer: line items in, one pixel item per
// pixel out, compared against an in-bench midpoint stepper. Uses mlr_pkg for the coordinate width.
`timescale 1ns / 1ps

module midpoint_line_rasterizer_tb;
    import mlr_pkg::*;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int CMIN       = -(1 << (CW - 1));
    localparam int CMAX       = (1 << (CW - 1)) - 1;
    localparam int N_RANDOM   = 330;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 80;

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } line_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 fin;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [CW-1:0] start_x = '0;
    logic signed [CW-1:0] start_y = '0;
    logic signed [CW-1:0] end_x = '0;
    logic signed [CW-1:0] end_y = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [CW-1:0] pixel_x;
    logic signed [CW-1:0] pixel_y;
    logic                 last;

    line_t  pending_lines[$];
    pixel_t expected_pixels[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     in_gap = 0;
    int     in_calm = 0;
    int     out_stall = 0;
    int     out_calm = 0;

    midpoint_line_rasterizer #(.COORD_WIDTH(CW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_line(int sx, int sy, int ex, int ey);
        line_t l;
        l.sx = CW'(sx);
        l.sy = CW'(sy);
        l.ex = CW'(ex);
        l.ey = CW'(ey);
        pending_lines.push_back(l);
    endfunction

    // Midpoint stepper: expected pixels of one line, in emission order
    function automatic void trace_line(line_t l);
        int     maj0, min0, maj1, min1, dmaj, dmin, dec, t, ma, mi;
        bit     steep;
        pixel_t p;
        steep = iabs(int'(l.ey) - int'(l.sy)) > iabs(int'(l.ex) - int'(l.sx));
        if (steep)
        begin
            maj0 = int'(l.sy); min0 = int'(l.sx); maj1 = int'(l.ey); min1 = int'(l.ex);
        end
        else
        begin
            maj0 = int'(l.sx); min0 = int'(l.sy); maj1 = int'(l.ex); min1 = int'(l.ey);
        end
        if (maj1 < maj0)
        begin
            t = maj0; maj0 = maj1; maj1 = t;
            t = min0; min0 = min1; min1 = t;
        end
        dmaj = maj1 - maj0;
        dmin = iabs(min1 - min0);
        dec  = 2 * dmin - dmaj;
        mi   = min0;
        for (ma = maj0; ma <= maj1; ma++)
        begin
            p.x   = CW'(steep ? mi : ma);
            p.y   = CW'(steep ? ma : mi);
            p.fin = (ma == maj1);
            expected_pixels.push_back(p);
            if (dec > 0)
            begin
                mi  += (min1 < min0) ? -1 : 1;
                dec -= 2 * dmaj;
            end
            dec += 2 * dmin;
        end
    endfunction

    // Line driver
    always @(posedge clk)
    begin
        bit take;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            take = in_valid && in_ready;
            if (take)
            begin
                trace_line(pending_lines.pop_front());
                in_gap = pick_gap(in_calm);
            end
            if (in_valid && !take)
            begin
                // hold until accepted
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_lines.size() > 0)
            begin
                start_x  <= pending_lines[0].sx;
                start_y  <= pending_lines[0].sy;
                end_x    <= pending_lines[0].ex;
                end_y    <= pending_lines[0].ey;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor, output back-pressure and watchdog
    always @(posedge clk)
    begin
        pixel_t want;
        logic   rdy_next;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel item with none expected: x=%0d y=%0d last=%0b",
                           pixel_x, pixel_y, last);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
                        errors++;
                    end
                    if (pixel_y !== want.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
                        errors++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0b, got %0b", want.fin, last);
                        errors++;
                    end
                end
                out_stall = pick_gap(out_calm);
            end
            else if (!out_ready && out_stall == 0 && $urandom_range(0, 15) == 0)
            begin
                out_stall = pick_gap(out_calm);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                rdy_next = 1'b0;
            end
            else
            begin
                rdy_next = 1'b1;
            end
            out_ready <= rdy_next;

            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL midpoint_line_rasterizer");
                $finish;
            end
        end
    end

    initial
    begin
        int r, sx, sy, d;

        // single points at two corners and the center
        add_line(0, 0, 0, 0);
        add_line(CMIN, CMIN, CMIN, CMIN);
        add_line(CMAX, CMAX, CMAX, CMAX);
        // full-span diagonals, forward and reversed
        add_line(CMIN, CMIN, CMAX, CMAX);
        add_line(CMAX, CMIN, CMIN, CMAX);
        add_line(CMAX, CMAX, CMIN, CMIN);
        // horizontal and vertical, both directions
        add_line(CMIN, 5, CMAX, 5);
        add_line(CMAX, -7, CMIN, -7);
        add_line(3, CMAX, 3, CMIN);
        add_line(-4, CMIN, -4, CMAX);
        // shallow and steep, positive and negative slope, forward and reversed
        add_line(CMIN, -3, CMAX, 9);
        add_line(CMAX, 2, CMIN, -11);
        add_line(-20, 10, 25, -5);
        add_line(-2, CMIN, 9, CMAX);
        add_line(6, CMAX, -5, CMIN);
        add_line(10, -30, -3, 28);
        add_line(-8, 30, 4, -29);
        // midpoint ties
        add_line(0, 0, 2, 1);
        add_line(0, 0, 1, 2);
        add_line(CMAX, 0, CMAX - 4, -2);
        add_line(-10, -10, 10, 0);
        // one-step lines
        add_line(0, 0, 1, 0);
        add_line(0, 0, 0, -1);
        add_line(CMAX, CMAX, CMAX - 1, CMAX - 1);

        repeat (N_RANDOM)
        begin
            r  = $urandom_range(0, 99);
            sx = rand_coord();
            sy = rand_coord();
            if (r < 40)
            begin
                add_line(sx, sy, rand_coord(), rand_coord());
            end
            else if (r < 65)
            begin
                add_line(sx, sy, clamp_coord(sx + int'($urandom_range(0, 8)) - 4),
                         clamp_coord(sy + int'($urandom_range(0, 8)) - 4));
            end
            else if (r < 75)
            begin
                if ($urandom_range(0, 1))
                    add_line(sx, sy, rand_coord(), sy);
                else
                    add_line(sx, sy, sx, rand_coord());
            end
            else if (r < 85)
            begin
                d = $urandom_range(0, 40) - 20;
                add_line(sx, sy, clamp_coord(sx + d),
                         clamp_coord(sy + ($urandom_range(0, 1) ? d : -d)));
            end
            else
            begin
                // even major delta with half minor delta lands on ties unless a coordinate is clamped
                d = 2 * int'($urandom_range(1, 15));
                sx = clamp_coord(sx);
                if ($urandom_range(0, 1))
                    add_line(sx, sy, clamp_coord(sx + ($urandom_range(0, 1) ? d : -d)),
                             clamp_coord(sy + ($urandom_range(0, 1) ? d / 2 : -d / 2)));
                else
                    add_line(sx, sy, clamp_coord(sx + ($urandom_range(0, 1) ? d / 2 : -d / 2)),
                             clamp_coord(sy + ($urandom_range(0, 1) ? d : -d)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_lines.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0 && expected_pixels.size() == 0)
            $display("PASS midpoint_line_rasterizer");
        else
            $display("FAIL midpoint_line_rasterizer");
        $finish;
    end

endmodule

[sim.f]
sv/mlr_pkg.sv
sv/mlr_ctrl.sv
sv/mlr_dp.sv
sv/midpoint_line_rasterizer.sv
dv/midpoint_line_rasterizer_tb.sv
